/* hdl/ilu_pkg.sv */
// Shared types, codes and reset values for the inverted-level serial transmitter and receiver.
package ilu_pkg;

  localparam int TIMER_BITS_DEF = 16;
  localparam int BIT_PERIOD_W   = 16;
  localparam int TIMEOUT_W      = 24;
  localparam int DATA_W         = 8;
  localparam int CFG_INDEX_W    = 1;
  localparam int CFG_DATA_W     = 24;

  localparam logic [BIT_PERIOD_W-1:0] BIT_PERIOD_RST = 16'd833;
  localparam logic [TIMEOUT_W-1:0]    RX_TIMEOUT_RST = 24'd30000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BIT_PERIOD = 1'b0,
    REG_RX_TIMEOUT = 1'b1
  } cfg_reg_t;

  typedef logic [3:0] bit_idx_t;

  // Transmitter bit positions
  localparam bit_idx_t TX_IDLE  = 4'd0;
  localparam bit_idx_t TX_START = 4'd1;
  localparam bit_idx_t TX_STOP  = 4'd10;
  localparam bit_idx_t TX_END   = 4'd11;

  // Receiver bit positions
  localparam bit_idx_t RX_IDLE       = 4'd0;
  localparam bit_idx_t RX_ARMED      = 4'd1;
  localparam bit_idx_t RX_HALF       = 4'd2;
  localparam bit_idx_t RX_FIRST_DATA = 4'd3;
  localparam bit_idx_t RX_LAST_DATA  = 4'd10;
  localparam bit_idx_t RX_STOP       = 4'd11;

  typedef struct packed {
    logic line;
    logic busy;
  } tx_res_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DATA_W-1:0] data;
    logic              timed_out;
  } rx_res_t;

endpackage

/* hdl/inverted_level_uart_tx_rx.sv */
// Top level of the inverted-level 8N1 serial transmitter and receiver.
// Each input request is one clock tick of the serial unit: it carries the sampled
// receive pin and optional transmit and receive starts, and yields one result with
// the pin levels and status after that tick. Requests pass an input register and
// then the sequencer logic into the output register, so one request is taken
// every cycle while results are not stalled; out_valid rises once a request moves
// from the input register into the output register, ready to be taken at the next
// edge; the output register lets the next request in while a result still waits.
// Line levels are inverted (idle low, start high, data one low, stop low).
// bit_period and rx_timeout_ticks must be written through the cfg port while idle
// (the block does not check); zero periods act as one, beyond TIMER_BITS saturate.
module inverted_level_uart_tx_rx #(
  parameter int TIMER_BITS = ilu_pkg::TIMER_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_rx_line,
  input  logic                            in_tx_request,
  input  logic [ilu_pkg::DATA_W-1:0]      in_tx_data,
  input  logic                            in_rx_request,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_tx_line,
  output logic                            out_tx_busy,
  output logic                            out_rx_busy,
  output logic                            out_rx_done,
  output logic [ilu_pkg::DATA_W-1:0]      out_rx_byte,
  output logic                            out_rx_timed_out,
  // configuration
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ilu_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ilu_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic [ilu_pkg::BIT_PERIOD_W-1:0] bit_period_r;
  logic [ilu_pkg::TIMEOUT_W-1:0]    rx_timeout_r;

  logic                       in_valid_r;
  logic                       rx_line_r, tx_req_r, rx_req_r;
  logic [ilu_pkg::DATA_W-1:0] tx_data_r;
  logic                       in_accept, adv;

  logic                       out_valid_r;
  ilu_pkg::tx_res_t           tx_res, tx_res_r;
  ilu_pkg::rx_res_t           rx_res, rx_res_r;

  logic [31:0]                bp_w, hp_w;
  logic [TIMER_BITS-1:0]      full, half;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_period_r <= ilu_pkg::BIT_PERIOD_RST;
      rx_timeout_r <= ilu_pkg::RX_TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (ilu_pkg::cfg_reg_t'(cfg_index))
        ilu_pkg::REG_BIT_PERIOD: bit_period_r <= cfg_data[ilu_pkg::BIT_PERIOD_W-1:0];
        ilu_pkg::REG_RX_TIMEOUT: rx_timeout_r <= cfg_data[ilu_pkg::TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // timer loads: saturate to the timer width, zero acts as one
  always_comb begin
    bp_w = 32'(bit_period_r);
    hp_w = bp_w >> 1;
    if ((bp_w >> TIMER_BITS) != 32'd0) begin
      full = '1;
    end else if (bp_w == 32'd0) begin
      full = {{(TIMER_BITS-1){1'b0}}, 1'b1};
    end else begin
      full = bp_w[TIMER_BITS-1:0];
    end
    if ((hp_w >> TIMER_BITS) != 32'd0) begin
      half = '1;
    end else if (hp_w == 32'd0) begin
      half = {{(TIMER_BITS-1){1'b0}}, 1'b1};
    end else begin
      half = hp_w[TIMER_BITS-1:0];
    end
  end

  // input register: advance into the result register when it is free or draining
  assign adv       = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !adv;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_accept) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      rx_line_r <= in_rx_line;
      tx_req_r  <= in_tx_request;
      tx_data_r <= in_tx_data;
      rx_req_r  <= in_rx_request;
    end
  end

  ilu_tx #(
    .TIMER_BITS (TIMER_BITS)
  ) u_tx (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .full  (full),
    .req   (tx_req_r),
    .data  (tx_data_r),
    .res   (tx_res)
  );

  ilu_rx #(
    .TIMER_BITS (TIMER_BITS)
  ) u_rx (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .full    (full),
    .half    (half),
    .timeout (rx_timeout_r),
    .line    (rx_line_r),
    .req     (rx_req_r),
    .res     (rx_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tx_res_r <= tx_res;
      rx_res_r <= rx_res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_tx_line      = tx_res_r.line;
  assign out_tx_busy      = tx_res_r.busy;
  assign out_rx_busy      = rx_res_r.busy;
  assign out_rx_done      = rx_res_r.done;
  assign out_rx_byte      = rx_res_r.data;
  assign out_rx_timed_out = rx_res_r.timed_out;

`ifndef NO_ASSERTIONS
  a_done_tmo_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_rx_done && out_rx_timed_out))
    else $error("rx done and timeout in the same result");

  a_idle_line_low: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tx_busy) |-> !out_tx_line)
    else $error("tx line high while transmitter idle");

  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_rx_done) |-> (out_rx_byte == '0))
    else $error("rx byte nonzero without rx done");

  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_valid_r && out_valid_r && out_stall))
    else $error("request stalled while a stage is free");
`endif

endmodule

/* hdl/ilu_tx.sv */
// Transmit bit sequencer: start bit, eight inverted data bits LSB first, stop bit.
module ilu_tx #(
  parameter int TIMER_BITS = ilu_pkg::TIMER_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic [TIMER_BITS-1:0]      full,
  input  logic                       req,
  input  logic [ilu_pkg::DATA_W-1:0] data,
  output ilu_pkg::tx_res_t           res
);

  logic [TIMER_BITS-1:0]      timer_r, timer_nxt;
  ilu_pkg::bit_idx_t          idx_r, idx_nxt, idx_inc;
  logic [ilu_pkg::DATA_W-1:0] shift_r, shift_nxt;
  logic                       level_r, level_nxt;

  always_comb begin
    timer_nxt = timer_r;
    idx_nxt   = idx_r;
    shift_nxt = shift_r;
    level_nxt = level_r;
    idx_inc   = idx_r + 4'd1;
    if (en) begin
      if (idx_r != ilu_pkg::TX_IDLE) begin
        timer_nxt = timer_r - TIMER_BITS'(1);
        if (timer_nxt == '0) begin
          if (idx_inc >= ilu_pkg::TX_END) begin
            idx_nxt   = ilu_pkg::TX_IDLE;
            level_nxt = 1'b0;
          end else if (idx_inc == ilu_pkg::TX_STOP) begin
            idx_nxt   = idx_inc;
            level_nxt = 1'b0;
            timer_nxt = full;
          end else begin
            // data bit 1 goes out low
            idx_nxt   = idx_inc;
            level_nxt = ~shift_r[0];
            shift_nxt = {1'b0, shift_r[ilu_pkg::DATA_W-1:1]};
            timer_nxt = full;
          end
        end
      end
      if (idx_nxt == ilu_pkg::TX_IDLE && req) begin
        idx_nxt   = ilu_pkg::TX_START;
        level_nxt = 1'b1;
        shift_nxt = data;
        timer_nxt = full;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_r <= '0;
      idx_r   <= ilu_pkg::TX_IDLE;
      shift_r <= '0;
      level_r <= 1'b0;
    end else begin
      timer_r <= timer_nxt;
      idx_r   <= idx_nxt;
      shift_r <= shift_nxt;
      level_r <= level_nxt;
    end
  end

  assign res.line = level_nxt;
  assign res.busy = (idx_nxt != ilu_pkg::TX_IDLE);

endmodule

/* hdl/ilu_rx.sv */
// Receive bit sequencer: start-bit wait with timeout, mid-bit sampling, stop-bit skip.
module ilu_rx #(
  parameter int TIMER_BITS = ilu_pkg::TIMER_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic [TIMER_BITS-1:0]         full,
  input  logic [TIMER_BITS-1:0]         half,
  input  logic [ilu_pkg::TIMEOUT_W-1:0] timeout,
  input  logic                          line,
  input  logic                          req,
  output ilu_pkg::rx_res_t              res
);

  logic [TIMER_BITS-1:0]         timer_r, timer_nxt;
  ilu_pkg::bit_idx_t             idx_r, idx_nxt;
  logic [ilu_pkg::DATA_W-1:0]    shift_r, shift_nxt;
  logic [ilu_pkg::TIMEOUT_W-1:0] wait_r, wait_nxt;
  logic                          done, tmo;

  always_comb begin
    timer_nxt = timer_r;
    idx_nxt   = idx_r;
    shift_nxt = shift_r;
    wait_nxt  = wait_r;
    done      = 1'b0;
    tmo       = 1'b0;
    if (en) begin
      if (idx_r == ilu_pkg::RX_ARMED) begin
        if (line) begin
          idx_nxt   = ilu_pkg::RX_HALF;
          shift_nxt = '0;
          timer_nxt = half;
        end else begin
          wait_nxt = wait_r + ilu_pkg::TIMEOUT_W'(1);
          if (wait_nxt >= timeout) begin
            tmo     = 1'b1;
            idx_nxt = ilu_pkg::RX_IDLE;
          end
        end
      end else if (idx_r != ilu_pkg::RX_IDLE) begin
        timer_nxt = timer_r - TIMER_BITS'(1);
        if (timer_nxt == '0) begin
          if (idx_r >= ilu_pkg::RX_FIRST_DATA && idx_r <= ilu_pkg::RX_LAST_DATA) begin
            shift_nxt = {~line, shift_r[ilu_pkg::DATA_W-1:1]};
          end
          if (idx_r >= ilu_pkg::RX_STOP) begin
            done    = 1'b1;
            idx_nxt = ilu_pkg::RX_IDLE;
          end else begin
            idx_nxt   = idx_r + 4'd1;
            timer_nxt = full;
          end
        end
      end
      if (idx_nxt == ilu_pkg::RX_IDLE && req) begin
        idx_nxt  = ilu_pkg::RX_ARMED;
        wait_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_r <= '0;
      idx_r   <= ilu_pkg::RX_IDLE;
      shift_r <= '0;
      wait_r  <= '0;
    end else begin
      timer_r <= timer_nxt;
      idx_r   <= idx_nxt;
      shift_r <= shift_nxt;
      wait_r  <= wait_nxt;
    end
  end

  assign res.busy      = (idx_nxt != ilu_pkg::RX_IDLE);
  assign res.done      = done;
  assign res.data      = done ? shift_nxt : '0;
  assign res.timed_out = tmo;

endmodule

/* tb/sv/ilu_tick_checker.sv */
// Tick-by-tick predictor and result checker for the inverted-level serial unit.
`timescale 1ns / 100ps
module ilu_tick_checker
  import ilu_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic                   in_rx_line,
  input  logic                   in_tx_request,
  input  logic [DATA_W-1:0]      in_tx_data,
  input  logic                   in_rx_request,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic                   out_tx_line,
  input  logic                   out_tx_busy,
  input  logic                   out_rx_busy,
  input  logic                   out_rx_done,
  input  logic [DATA_W-1:0]      out_rx_byte,
  input  logic                   out_rx_timed_out,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     fail_count,
  output int                     queued,
  output logic                   serial_idle,
  output int                     ticks_checked,
  output int                     bytes_done,
  output int                     waits_expired
);

  typedef struct packed {
    logic              tx_line;
    logic              tx_busy;
    logic              rx_busy;
    logic              rx_done;
    logic [DATA_W-1:0] rx_byte;
    logic              rx_timed_out;
  } tick_status_t;

  // bit period is 16 bits wide, so it always fits the default timer width
  logic [BIT_PERIOD_W-1:0]   period_cfg;
  logic [TIMEOUT_W-1:0]      timeout_cfg;
  logic [TIMER_BITS_DEF-1:0] tx_tmr;
  bit_idx_t                  tx_pos;
  logic [DATA_W-1:0]         tx_sh;
  logic                      tx_lvl;
  logic [TIMER_BITS_DEF-1:0] rx_tmr;
  bit_idx_t                  rx_pos;
  logic [DATA_W-1:0]         rx_sh;
  logic [TIMEOUT_W-1:0]      rx_waited;

  tick_status_t status_q[$];
  tick_status_t want;
  int errors;
  int n_checked;
  int n_bytes;
  int n_expired;

  function automatic logic [TIMER_BITS_DEF-1:0] at_least_one(logic [BIT_PERIOD_W-1:0] v);
    return (v == '0) ? TIMER_BITS_DEF'(1) : TIMER_BITS_DEF'(v);
  endfunction

  function automatic tick_status_t step_serial(logic line, logic tx_go, logic [DATA_W-1:0] tx_val,
                                               logic rx_go);
    logic [TIMER_BITS_DEF-1:0] reload;
    tick_status_t st;
    reload = at_least_one(period_cfg);
    st = '0;
    // running units advance before new requests are taken
    if (tx_pos != TX_IDLE) begin
      tx_tmr = tx_tmr - TIMER_BITS_DEF'(1);
      if (tx_tmr == '0) begin
        tx_pos = tx_pos + 4'd1;
        if (tx_pos >= TX_END) begin
          tx_pos = TX_IDLE;
          tx_lvl = 1'b0;
        end else if (tx_pos == TX_STOP) begin
          tx_lvl = 1'b0;
          tx_tmr = reload;
        end else begin
          tx_lvl = ~tx_sh[0];
          tx_sh = tx_sh >> 1;
          tx_tmr = reload;
        end
      end
    end
    if (rx_pos == RX_ARMED) begin
      if (line) begin
        rx_pos = RX_HALF;
        rx_sh = '0;
        rx_tmr = at_least_one(period_cfg >> 1);
      end else begin
        rx_waited = rx_waited + TIMEOUT_W'(1);
        if (rx_waited >= timeout_cfg) begin
          st.rx_timed_out = 1'b1;
          rx_pos = RX_IDLE;
        end
      end
    end else if (rx_pos != RX_IDLE) begin
      rx_tmr = rx_tmr - TIMER_BITS_DEF'(1);
      if (rx_tmr == '0) begin
        if (rx_pos >= RX_FIRST_DATA && rx_pos <= RX_LAST_DATA) rx_sh = {~line, rx_sh[DATA_W-1:1]};
        if (rx_pos >= RX_STOP) begin
          st.rx_done = 1'b1;
          st.rx_byte = rx_sh;
          rx_pos = RX_IDLE;
        end else begin
          rx_pos = rx_pos + 4'd1;
          rx_tmr = reload;
        end
      end
    end
    if (tx_pos == TX_IDLE && tx_go) begin
      tx_pos = TX_START;
      tx_lvl = 1'b1;
      tx_sh = tx_val;
      tx_tmr = reload;
    end
    if (rx_pos == RX_IDLE && rx_go) begin
      rx_pos = RX_ARMED;
      rx_waited = '0;
    end
    st.tx_line = tx_lvl;
    st.tx_busy = (tx_pos != TX_IDLE);
    st.rx_busy = (rx_pos != RX_IDLE);
    return st;
  endfunction

  function automatic void check_field(string name, logic [DATA_W-1:0] want_v,
                                      logic [DATA_W-1:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want_v, got_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      period_cfg = BIT_PERIOD_RST;
      timeout_cfg = RX_TIMEOUT_RST;
      tx_tmr = '0;
      tx_pos = TX_IDLE;
      tx_sh = '0;
      tx_lvl = 1'b0;
      rx_tmr = '0;
      rx_pos = RX_IDLE;
      rx_sh = '0;
      rx_waited = '0;
      status_q.delete();
      errors = 0;
      n_checked = 0;
      n_bytes = 0;
      n_expired = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_BIT_PERIOD: period_cfg = cfg_data[BIT_PERIOD_W-1:0];
          REG_RX_TIMEOUT: timeout_cfg = cfg_data[TIMEOUT_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (status_q.size() == 0) begin
          $display("%0t: result with no request outstanding", $time);
          errors++;
        end else begin
          want = status_q.pop_front();
          n_checked++;
          check_field("tx_line", DATA_W'(want.tx_line), DATA_W'(out_tx_line));
          check_field("tx_busy", DATA_W'(want.tx_busy), DATA_W'(out_tx_busy));
          check_field("rx_busy", DATA_W'(want.rx_busy), DATA_W'(out_rx_busy));
          check_field("rx_done", DATA_W'(want.rx_done), DATA_W'(out_rx_done));
          check_field("rx_byte", want.rx_byte, out_rx_byte);
          check_field("rx_timed_out", DATA_W'(want.rx_timed_out), DATA_W'(out_rx_timed_out));
        end
      end
      if (in_valid && !in_stall) begin
        want = step_serial(in_rx_line, in_tx_request, in_tx_data, in_rx_request);
        if (want.rx_done) n_bytes++;
        if (want.rx_timed_out) n_expired++;
        status_q.push_back(want);
      end
    end
    // publish after the edge so readers at the edge see a settled value
    fail_count <= errors;
    queued <= status_q.size();
    serial_idle <= (tx_pos == TX_IDLE) && (rx_pos == RX_IDLE);
    ticks_checked <= n_checked;
    bytes_done <= n_bytes;
    waits_expired <= n_expired;
  end

endmodule

/* tb/sv/tb.sv */
// Stimulus, flow control and verdict for the inverted-level serial unit.
`timescale 1ns / 100ps
module tb;
  import ilu_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int LONG_HOLD   = 400;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   in_rx_line = 1'b0;
  logic                   in_tx_request = 1'b0;
  logic [DATA_W-1:0]      in_tx_data = '0;
  logic                   in_rx_request = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   out_tx_line;
  logic                   out_tx_busy;
  logic                   out_rx_busy;
  logic                   out_rx_done;
  logic [DATA_W-1:0]      out_rx_byte;
  logic                   out_rx_timed_out;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int   fail_count;
  int   queued;
  logic serial_idle;
  int   ticks_checked;
  int   bytes_done;
  int   waits_expired;

  int          burst_left = 0;
  int          settings_used = 0;
  int          quiet_cycles = 0;
  logic        long_hold_go = 1'b0;
  logic        long_hold_done;
  int          hold_left;
  int          mode_left;
  stall_mode_t stall_mode;

  inverted_level_uart_tx_rx i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_line       (in_rx_line),
    .in_tx_request    (in_tx_request),
    .in_tx_data       (in_tx_data),
    .in_rx_request    (in_rx_request),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_tx_line      (out_tx_line),
    .out_tx_busy      (out_tx_busy),
    .out_rx_busy      (out_rx_busy),
    .out_rx_done      (out_rx_done),
    .out_rx_byte      (out_rx_byte),
    .out_rx_timed_out (out_rx_timed_out),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  ilu_tick_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_line       (in_rx_line),
    .in_tx_request    (in_tx_request),
    .in_tx_data       (in_tx_data),
    .in_rx_request    (in_rx_request),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_tx_line      (out_tx_line),
    .out_tx_busy      (out_tx_busy),
    .out_rx_busy      (out_rx_busy),
    .out_rx_done      (out_rx_done),
    .out_rx_byte      (out_rx_byte),
    .out_rx_timed_out (out_rx_timed_out),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .queued           (queued),
    .serial_idle      (serial_idle),
    .ticks_checked    (ticks_checked),
    .bytes_done       (bytes_done),
    .waits_expired    (waits_expired)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // result side: random stall modes, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      long_hold_done = 1'b0;
      hold_left = 0;
      mode_left = 0;
      stall_mode = STALL_NONE;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (long_hold_go && !long_hold_done) begin
      long_hold_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 9) < 3);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
        default:     out_stall <= ~out_stall;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: no handshake for %0d cycles", quiet_cycles);
      $display("tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_mode(input logic [CFG_DATA_W-1:0] period, input logic [CFG_DATA_W-1:0] timeout);
    write_reg(REG_BIT_PERIOD, period);
    write_reg(REG_RX_TIMEOUT, timeout);
    settings_used++;
  endtask

  // offer one tick request in bursts with random gaps; return at its handshake
  task automatic send_tick(input logic line, input logic tx_go, input logic [DATA_W-1:0] tx_val,
                           input logic rx_go);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_rx_line <= line;
    in_tx_request <= tx_go;
    in_tx_data <= tx_val;
    in_rx_request <= rx_go;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (queued != 0);
  endtask

  // feed quiet line ticks until both serial units are idle, then empty the pipe
  task automatic drain_serial();
    in_valid <= 1'b0;
    @(posedge clk);
    while (!serial_idle) send_tick(1'b0, 1'b0, '0, 1'b0);
    wait_results();
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input logic [BIT_PERIOD_W-1:0] period,
                           input logic [TIMEOUT_W-1:0] timeout, input int n_ticks);
    bit                line_plan[$];
    int                lead;
    int                bit_len;
    int                pause_at;
    logic              arm;
    logic              rx_go;
    logic [DATA_W-1:0] rx_val;
    set_mode({8'($urandom), period}, timeout);
    pause_at = $urandom_range(0, n_ticks - 1);
    arm = 1'b0;
    for (int k = 0; k < n_ticks; k++) begin
      if (k == pause_at) wait_results();
      if (line_plan.size() == 0) begin
        if ($urandom_range(0, 9) < 7) begin
          // well-formed: arm, quiet lead-in, start, eight data bits, stop
          arm = 1'b1;
          rx_val = 8'($urandom);
          bit_len = (period == 0) ? 1 : ((period <= 256) ? period : $urandom_range(1, 16));
          lead = ($urandom_range(0, 3) == 0) ?
                 $urandom_range(1, (timeout < 400) ? int'(timeout) + 2 : 400) :
                 $urandom_range(1, 3);
          repeat (lead) line_plan.push_back(1'b0);
          repeat (bit_len) line_plan.push_back(1'b1);
          for (int b = 0; b < DATA_W; b++) begin
            repeat (bit_len) line_plan.push_back(~rx_val[b]);
          end
          repeat (bit_len) line_plan.push_back(1'b0);
        end else begin
          repeat ($urandom_range(1, 24)) line_plan.push_back(1'($urandom));
        end
      end
      rx_go = arm | ($urandom_range(0, 15) == 0);
      arm = 1'b0;
      send_tick(line_plan.pop_front(), ($urandom_range(0, 3) == 0), 8'($urandom), rx_go);
    end
  endtask

  initial begin
    logic [DATA_W-1:0] probe;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one-tick bits and a one-tick wait: the half-bit wait rounds up to one
    set_mode(1, 1);
    send_tick(1'b0, 1'b1, 8'hFF, 1'b1);
    send_tick(1'b0, 1'b0, 8'h00, 1'b0);
    send_tick(1'b0, 1'b1, 8'h00, 1'b1);
    send_tick(1'b1, 1'b0, 8'h00, 1'b0);
    probe = 8'h3C;
    send_tick(1'b1, 1'b0, 8'h00, 1'b0);
    for (int b = 0; b < DATA_W; b++) send_tick(~probe[b], 1'b0, 8'h00, 1'b0);
    // requests on the tick the receiver delivers are taken
    send_tick(1'b0, 1'b1, 8'h00, 1'b1);
    send_tick(1'b0, 1'b0, 8'h00, 1'b0);
    drain_serial();

    // zero period and zero wait both behave as one
    set_mode(0, 0);
    send_tick(1'b0, 1'b1, 8'h81, 1'b1);
    send_tick(1'b0, 1'b0, 8'h00, 1'b0);
    send_tick(1'b1, 1'b0, 8'h00, 1'b1);
    send_tick(1'b1, 1'b1, 8'hFF, 1'b0);
    send_tick(1'b0, 1'b0, 8'h00, 1'b0);
    send_tick(1'b0, 1'b0, 8'h00, 1'b0);
    drain_serial();

    run_phase(2, 3, 100);
    drain_serial();
    long_hold_go <= 1'b1;
    run_phase(3, 40, 150);
    drain_serial();
    run_phase(5, 80, 130);
    drain_serial();
    run_phase(8, 200, 130);
    drain_serial();
    run_phase(1, 2, 100);
    drain_serial();
    for (int n = 0; n < 3; n++) begin
      run_phase(16'($urandom_range(1, 12)), 24'($urandom_range(1, 250)), 100);
      drain_serial();
    end
    run_phase(40, 300, 80);
    drain_serial();
    // widest settings last: the frame in flight is never waited out
    run_phase(16'hFFFF, 24'hFFFFFF, 60);
    wait_results();
    repeat (8) @(posedge clk);

    $display("tb: %0d ticks checked across %0d register settings", ticks_checked, settings_used);
    $display("tb: %0d bytes received, %0d start-bit waits expired", bytes_done, waits_expired);
    if (fail_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/ilu_pkg.sv
hdl/ilu_tx.sv
hdl/ilu_rx.sv
hdl/inverted_level_uart_tx_rx.sv
tb/sv/ilu_tick_checker.sv
tb/sv/tb.sv
